>>> sv/hpgov_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hpgov_pkg
// Shared types, codes and helpers of the core hotplug load governor.
// ----------------------------------------------------------------------------
package hpgov_pkg;

  localparam int NUM_CORES = 8;
  localparam int CORE_W    = 3;
  localparam int FREQ_W    = 22;
  localparam int CNT_W     = $clog2(NUM_CORES + 1);
  localparam int PROD_W    = 29;
  localparam int SCALED_W  = 30;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 22;

  // Command codes on the request channel
  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_OFF    = 2'd1;
  localparam logic [1:0] CMD_ON     = 2'd2;

  // Operation codes carried through the queue
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_OFF    = 2'd1;
  localparam logic [1:0] OP_ON     = 2'd2;

  // Result action codes
  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_UP       = 3'd1;
  localparam logic [2:0] ACT_DOWN     = 3'd2;
  localparam logic [2:0] ACT_ALL_DOWN = 3'd3;
  localparam logic [2:0] ACT_ALL_UP   = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_UP_PCT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_PCT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ONLINE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ONLINE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_UP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_DOWN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FREQ   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GOV_ON     = 3'd7;

  localparam logic [NUM_CORES-1:0] ALL_CORES = {NUM_CORES{1'b1}};
  localparam logic [FREQ_W:0]      SLOW_SENTINEL = {(FREQ_W+1){1'b1}};

  typedef struct packed {
    logic [1:0]        cmd;
    logic [CORE_W-1:0] core_index;
    logic [FREQ_W-1:0] freq_khz;
    logic              last_sample;
  } in_item_t;

  typedef struct packed {
    logic [2:0]           action;
    logic [CORE_W-1:0]    target_core;
    logic [NUM_CORES-1:0] online_mask;
    logic [CNT_W-1:0]     online_count;
  } out_item_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [CORE_W-1:0] core;
    logic              core_ok;
    logic              core0;
    logic [FREQ_W-1:0] freq;
    logic              last;
  } q_entry_t;

  typedef struct packed {
    logic [CNT_W-1:0]  max_online;
    logic [CNT_W-1:0]  min_online;
    logic [7:0]        ticks_up;
    logic [7:0]        ticks_down;
    logic              gov_on;
    logic [PROD_W-1:0] up_prod;
    logic [PROD_W-1:0] down_prod;
  } cfg_t;

  function automatic logic [CNT_W-1:0] popcount(input logic [NUM_CORES-1:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < NUM_CORES; i++) begin
      n = n + CNT_W'(v[i]);
    end
    return n;
  endfunction

  // x * 100 as shifts and adds
  function automatic logic [SCALED_W-1:0] mul100(input logic [FREQ_W:0] x);
    logic [SCALED_W-1:0] w;
    w = SCALED_W'(x);
    return (w << 6) + (w << 5) + (w << 2);
  endfunction

endpackage
`default_nettype wire

>>> sv/hpgov_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hpgov_front
// Classifies incoming requests and pushes them into the queue.
// ----------------------------------------------------------------------------
module hpgov_front (
  input  wire logic                in_valid,
  input  wire hpgov_pkg::in_item_t in_item,
  input  wire logic                q_full,
  output logic                     in_stall,
  output logic                     q_push,
  output hpgov_pkg::q_entry_t      q_wdata
);
  import hpgov_pkg::*;

  logic keep;

  // drop the unused command code here
  always_comb begin
    case (in_item.cmd)
      CMD_SAMPLE: begin keep = 1'b1; q_wdata.op = OP_SAMPLE; end
      CMD_OFF:    begin keep = 1'b1; q_wdata.op = OP_OFF;    end
      CMD_ON:     begin keep = 1'b1; q_wdata.op = OP_ON;     end
      default:    begin keep = 1'b0; q_wdata.op = OP_SAMPLE; end
    endcase
    q_wdata.core    = in_item.core_index;
    q_wdata.core_ok = ({1'b0, in_item.core_index} < (CORE_W+1)'(NUM_CORES));
    q_wdata.core0   = (in_item.core_index == '0);
    q_wdata.freq    = in_item.freq_khz;
    q_wdata.last    = in_item.last_sample;
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && keep;

endmodule
`default_nettype wire

>>> sv/hpgov_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hpgov_queue
// Four-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module hpgov_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire hpgov_pkg::q_entry_t wdata,
  input  wire logic                pop,
  output logic                     full,
  output logic                     q_valid,
  output hpgov_pkg::q_entry_t      rdata
);
  import hpgov_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  q_entry_t          mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]    cnt_r, cnt_nxt;

  assign full    = (cnt_r == (PTR_W+1)'(DEPTH));
  assign q_valid = (cnt_r != '0);
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sv/hpgov_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hpgov_back
// Tracks samples, makes the tick decision and holds the result register.
// ----------------------------------------------------------------------------
module hpgov_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire hpgov_pkg::cfg_t     cfg,
  input  wire logic                q_valid,
  input  wire hpgov_pkg::q_entry_t q_rdata,
  output logic                     q_pop,
  output logic                     out_valid,
  output hpgov_pkg::out_item_t     out_item,
  input  wire logic                out_stall
);
  import hpgov_pkg::*;

  logic [NUM_CORES-1:0] online_r, online_nxt;
  logic [7:0]           tick_r, tick_nxt;
  logic                 susp_r, susp_nxt;
  logic [FREQ_W-1:0]    core0_r, core0_nxt;
  logic [FREQ_W:0]      slow_r, slow_nxt;
  logic [CORE_W-1:0]    slow_core_r, slow_core_nxt;
  logic [FREQ_W-1:0]    fast_r, fast_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_item_r, out_item_nxt;

  logic                 fire;
  logic                 emit;
  logic [2:0]           act;
  logic [CORE_W-1:0]    tgt;
  logic [FREQ_W:0]      slow_m;
  logic [FREQ_W-1:0]    fast_m;
  logic [7:0]           tick_inc;
  logic [CNT_W-1:0]     n_on;
  logic                 up_hit, down_hit;
  logic                 free_found;
  logic [CORE_W-1:0]    free_core;

  assign fire      = q_valid && (!out_valid_r || !out_stall);
  assign q_pop     = fire;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // lowest offline core above core 0
  always_comb begin
    free_found = 1'b0;
    free_core  = '0;
    for (int i = 1; i < NUM_CORES; i++) begin
      if (!free_found && !online_r[i]) begin
        free_found = 1'b1;
        free_core  = CORE_W'(i);
      end
    end
  end

  always_comb begin
    online_nxt    = online_r;
    tick_nxt      = tick_r;
    susp_nxt      = susp_r;
    core0_nxt     = core0_r;
    slow_nxt      = slow_r;
    slow_core_nxt = slow_core_r;
    fast_nxt      = fast_r;
    emit          = 1'b0;
    act           = ACT_NONE;
    tgt           = '0;

    // tracker update for an online sample
    if (q_rdata.core_ok && online_r[q_rdata.core]) begin
      if (q_rdata.core0) begin
        core0_nxt = q_rdata.freq;
      end else if ({1'b0, q_rdata.freq} <= slow_r) begin
        slow_nxt      = {1'b0, q_rdata.freq};
        slow_core_nxt = q_rdata.core;
      end else if (q_rdata.freq > fast_r) begin
        fast_nxt = q_rdata.freq;
      end
    end

    // core 0 joins both extremes at the decision
    slow_m   = ({1'b0, core0_nxt} < slow_nxt) ? {1'b0, core0_nxt} : slow_nxt;
    fast_m   = (core0_nxt > fast_nxt) ? core0_nxt : fast_nxt;
    tick_inc = (tick_r == 8'hFF) ? tick_r : tick_r + 8'd1;
    n_on     = popcount(online_r);
    up_hit   = mul100(slow_m) > SCALED_W'(cfg.up_prod);
    down_hit = mul100({1'b0, fast_m} + (FREQ_W+1)'(1)) <= SCALED_W'(cfg.down_prod);

    if (!fire) begin
      online_nxt    = online_r;
      core0_nxt     = core0_r;
      slow_nxt      = slow_r;
      slow_core_nxt = slow_core_r;
      fast_nxt      = fast_r;
    end else begin
      case (q_rdata.op)
        OP_OFF: begin
          online_nxt = NUM_CORES'(1);
          susp_nxt   = 1'b1;
          core0_nxt  = core0_r;
          emit       = 1'b1;
          act        = ACT_ALL_DOWN;
        end
        OP_ON: begin
          online_nxt = ALL_CORES;
          susp_nxt   = 1'b0;
          core0_nxt  = core0_r;
          emit       = 1'b1;
          act        = ACT_ALL_UP;
        end
        default: begin
          if (!cfg.gov_on || susp_r) begin
            // hold trackers; a tick end only reloads them
            core0_nxt     = core0_r;
            slow_nxt      = slow_r;
            slow_core_nxt = slow_core_r;
            fast_nxt      = fast_r;
          end else if (q_rdata.last) begin
            emit     = 1'b1;
            tick_nxt = tick_inc;
            if (up_hit) begin
              if (n_on < cfg.max_online && tick_inc >= cfg.ticks_up) begin
                if (free_found) begin
                  online_nxt[free_core] = 1'b1;
                  act = ACT_UP;
                  tgt = free_core;
                end
                tick_nxt = '0;
              end
            end else if (slow_core_nxt != '0 && down_hit) begin
              if (n_on > cfg.min_online && tick_inc >= cfg.ticks_down) begin
                if (online_r[slow_core_nxt]) begin
                  online_nxt[slow_core_nxt] = 1'b0;
                  act = ACT_DOWN;
                  tgt = slow_core_nxt;
                end
                tick_nxt = '0;
              end
            end
          end
        end
      endcase
      // reload trackers at every tick end and screen event
      if (q_rdata.op != OP_SAMPLE || q_rdata.last) begin
        slow_nxt      = SLOW_SENTINEL;
        slow_core_nxt = '0;
        fast_nxt      = '0;
      end
    end

    out_item_nxt.action       = act;
    out_item_nxt.target_core  = tgt;
    out_item_nxt.online_mask  = online_nxt;
    out_item_nxt.online_count = popcount(online_nxt);

    if (fire && emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_item_r <= out_item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      online_r    <= ALL_CORES;
      tick_r      <= '0;
      susp_r      <= 1'b0;
      core0_r     <= '0;
      slow_r      <= SLOW_SENTINEL;
      slow_core_r <= '0;
      fast_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      online_r    <= online_nxt;
      tick_r      <= tick_nxt;
      susp_r      <= susp_nxt;
      core0_r     <= core0_nxt;
      slow_r      <= slow_nxt;
      slow_core_r <= slow_core_nxt;
      fast_r      <= fast_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sv/core_hotplug_load_governor_unit.sv
`default_nettype none
// A request goes through the queue and then the result register to out_valid.
// Throughput: one request per cycle unless q_full; the back part retires
//   one queue entry per cycle when the result register is free or being taken.
// A four-entry queue lets the input side keep going while a result is stalled.
// Reset (synchronous, rst_n low): default register values, every core online,
//   tick counter cleared, queue and result register empty.
// ----------------------------------------------------------------------------
// core_hotplug_load_governor_unit
// Decides which cores are online from per-tick frequency samples.
// ----------------------------------------------------------------------------
module core_hotplug_load_governor_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [hpgov_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [hpgov_pkg::CFG_DW-1:0]        cfg_wdata,
  input  wire logic                                in_valid,
  input  wire hpgov_pkg::in_item_t                 in_item,
  output logic                                     in_stall,
  output logic                                     out_valid,
  output hpgov_pkg::out_item_t                     out_item,
  input  wire logic                                out_stall
);
  import hpgov_pkg::*;

  // Configuration registers
  logic [6:0]        up_pct_r;
  logic [6:0]        down_pct_r;
  logic [3:0]        max_online_r;
  logic [3:0]        min_online_r;
  logic [7:0]        ticks_up_r;
  logic [7:0]        ticks_down_r;
  logic [FREQ_W-1:0] max_freq_r;
  logic              gov_on_r;

  // Thresholds kept as percent * max frequency; the back part compares
  // 100 * frequency against them, so no division is needed. They are
  // registered from the configuration registers.
  logic [PROD_W-1:0] up_prod_r;
  logic [PROD_W-1:0] down_prod_r;

  cfg_t     cfg;
  logic     q_full;
  logic     q_push;
  q_entry_t q_wdata;
  logic     q_pop;
  logic     q_valid;
  q_entry_t q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_pct_r     <= 7'd90;
      down_pct_r   <= 7'd60;
      max_online_r <= 4'd8;
      min_online_r <= 4'd2;
      ticks_up_r   <= 8'd1;
      ticks_down_r <= 8'd1;
      max_freq_r   <= FREQ_W'(2000000);
      gov_on_r     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_UP_PCT:     up_pct_r     <= cfg_wdata[6:0];
        REG_DOWN_PCT:   down_pct_r   <= cfg_wdata[6:0];
        REG_MAX_ONLINE: max_online_r <= cfg_wdata[3:0];
        REG_MIN_ONLINE: min_online_r <= cfg_wdata[3:0];
        REG_TICKS_UP:   ticks_up_r   <= cfg_wdata[7:0];
        REG_TICKS_DOWN: ticks_down_r <= cfg_wdata[7:0];
        REG_MAX_FREQ:   max_freq_r   <= cfg_wdata[FREQ_W-1:0];
        REG_GOV_ON:     gov_on_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Recompute thresholds every cycle from the current registers
  always_ff @(posedge clk) begin
    up_prod_r   <= PROD_W'(up_pct_r) * PROD_W'(max_freq_r);
    down_prod_r <= PROD_W'(down_pct_r) * PROD_W'(max_freq_r);
  end

  always_comb begin
    cfg.max_online = CNT_W'(max_online_r);
    cfg.min_online = CNT_W'(min_online_r);
    cfg.ticks_up   = ticks_up_r;
    cfg.ticks_down = ticks_down_r;
    cfg.gov_on     = gov_on_r;
    cfg.up_prod    = up_prod_r;
    cfg.down_prod  = down_prod_r;
  end

  // Front: classify each request, drop unused commands
  hpgov_front u_front (
    .in_valid (in_valid),
    .in_item  (in_item),
    .q_full   (q_full),
    .in_stall (in_stall),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  // Queue: decouple the front from the back
  hpgov_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wdata   (q_wdata),
    .pop     (q_pop),
    .full    (q_full),
    .q_valid (q_valid),
    .rdata   (q_rdata)
  );

  // Back: track, decide, hold the result
  hpgov_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall)
  );

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the core hotplug load governor: a short directed
// run over the corner cases, then phases of random ticks under varied
// register settings and handshake idling, checked against a cycle-free
// prediction of every decision.
// ----------------------------------------------------------------------------
module testbench;
  import hpgov_pkg::*;

  localparam int FREQ_MAX        = (1 << FREQ_W) - 1;
  localparam int NUM_REGS        = 8;
  localparam int DRAIN_CYCLES    = 12;    // enough to empty a full queue, with margin
  localparam int HOLD_OFF_CYCLES = 300;   // long receiver hold-off to back the block up
  localparam int SATURATE_TICKS  = 280;   // enough core-0-only ticks to pin the tick counter
  localparam int REPORT_LIMIT    = 100;   // stop printing mismatches after this many
  localparam int TIMEOUT_NS      = 4000000;

  // The one command code the block must ignore
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum int {LOAD_HIGH, LOAD_LOW, LOAD_ANY, LOAD_EDGE} load_t;
  typedef enum int {PH_DEFAULT, PH_RANDOM, PH_EXT_A, PH_EXT_B, PH_GOV_OFF, PH_SATURATE} phase_t;

  // --------------------------------------------------------------------------
  // Governor model and decision scoreboard. Every accepted request is folded
  // into the model state; each request that closes a tick while the governor
  // is on and awake (or toggles the screen) queues the decision the block must return.
  // --------------------------------------------------------------------------
  class hotplug_tracker;
    // register copies
    logic [6:0]           up_pct, down_pct;
    logic [3:0]           max_up, min_up;
    logic [7:0]           wait_up, wait_down;
    logic [FREQ_W-1:0]    max_khz;
    logic                 gov_on;
    // governor state
    logic [NUM_CORES-1:0] online;
    logic [7:0]           tick_count;
    bit                   asleep;
    logic [FREQ_W-1:0]    core0_khz;
    logic [FREQ_W:0]      low_khz;
    logic [CORE_W-1:0]    low_core;
    logic [FREQ_W-1:0]    high_khz;

    out_item_t            due_decisions[$];
    int                   predicted;
    int                   errors;

    function new();
      up_pct     = 7'd90;
      down_pct   = 7'd60;
      max_up     = 4'd8;
      min_up     = 4'd2;
      wait_up    = 8'd1;
      wait_down  = 8'd1;
      max_khz    = 22'd2000000;
      gov_on     = 1'b1;
      online     = ALL_CORES;
      tick_count = '0;
      asleep     = 1'b0;
      core0_khz  = '0;
      predicted  = 0;
      errors     = 0;
      restart_tick();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DW-1:0] data);
      case (idx)
        REG_UP_PCT:     up_pct    = data[6:0];
        REG_DOWN_PCT:   down_pct  = data[6:0];
        REG_MAX_ONLINE: max_up    = data[3:0];
        REG_MIN_ONLINE: min_up    = data[3:0];
        REG_TICKS_UP:   wait_up   = data[7:0];
        REG_TICKS_DOWN: wait_down = data[7:0];
        REG_MAX_FREQ:   max_khz   = data[FREQ_W-1:0];
        REG_GOV_ON:     gov_on    = data[0];
        default: ;
      endcase
    endfunction

    // Percent of the maximum frequency, rounded down
    function longint unsigned threshold(logic [6:0] pct);
      return (64'(pct) * 64'(max_khz)) / 64'd100;
    endfunction

    function void restart_tick();
      low_khz  = SLOW_SENTINEL;
      low_core = '0;
      high_khz = '0;
    endfunction

    function void push_decision(logic [2:0] act, logic [CORE_W-1:0] target);
      out_item_t d;
      d.action       = act;
      d.target_core  = target;
      d.online_mask  = online;
      d.online_count = CNT_W'($countones(online));
      due_decisions.push_back(d);
      predicted++;
    endfunction

    function void decide();
      longint unsigned slow, fast, up_khz, down_khz;
      int                n;
      bit                found;
      logic [2:0]        act;
      logic [CORE_W-1:0] target;
      n        = $countones(online);
      up_khz   = threshold(up_pct);
      down_khz = threshold(down_pct);
      act      = ACT_NONE;
      target   = '0;
      found    = 1'b0;
      if (tick_count != 8'hFF) tick_count++;
      // core 0 joins both trackers only now
      slow = 64'(low_khz);
      fast = 64'(high_khz);
      if (64'(core0_khz) < slow) slow = 64'(core0_khz);
      if (64'(core0_khz) > fast) fast = 64'(core0_khz);
      if (slow > up_khz) begin
        if (n < max_up && tick_count >= wait_up) begin
          for (int i = 1; i < NUM_CORES; i++) begin
            if (!found && !online[i]) begin
              online[i] = 1'b1;
              act       = ACT_UP;
              target    = CORE_W'(i);
              found     = 1'b1;
            end
          end
          tick_count = '0;
        end
      end else if (low_core != 0 && fast < down_khz) begin
        if (n > min_up && tick_count >= wait_down) begin
          if (online[low_core]) begin
            online[low_core] = 1'b0;
            act              = ACT_DOWN;
            target           = low_core;
          end
          tick_count = '0;
        end
      end
      restart_tick();
      push_decision(act, target);
    endfunction

    function void take_request(in_item_t req);
      case (req.cmd)
        CMD_OFF: begin
          online = {{(NUM_CORES-1){1'b0}}, 1'b1};
          asleep = 1'b1;
          restart_tick();
          push_decision(ACT_ALL_DOWN, '0);
        end
        CMD_ON: begin
          online = ALL_CORES;
          asleep = 1'b0;
          restart_tick();
          push_decision(ACT_ALL_UP, '0);
        end
        CMD_SAMPLE: begin
          if (!gov_on || asleep) begin
            if (req.last_sample) restart_tick();
          end else begin
            if (online[req.core_index]) begin
              if (req.core_index == 0) begin
                core0_khz = req.freq_khz;
              end else if ({1'b0, req.freq_khz} <= low_khz) begin
                low_core = req.core_index;
                low_khz  = {1'b0, req.freq_khz};
              end else if (req.freq_khz > high_khz) begin
                high_khz = req.freq_khz;
              end
            end
            if (req.last_sample) decide();
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] seen);
      if (seen !== want) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $error("%s: expected %0h, got %0h", name, want, seen);
      end
    endfunction

    function void take_decision(out_item_t got);
      out_item_t want;
      if (due_decisions.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $error("decision with none pending: action %0d target %0d mask %h count %0d",
                 got.action, got.target_core, got.online_mask, got.online_count);
        return;
      end
      want = due_decisions.pop_front();
      compare_field("action", 8'(want.action), 8'(got.action));
      compare_field("target_core", 8'(want.target_core), 8'(got.target_core));
      compare_field("online_mask", 8'(want.online_mask), 8'(got.online_mask));
      compare_field("online_count", 8'(want.online_count), 8'(got.online_count));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block ports. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DW-1:0]    cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  in_item_t             in_item   = '0;
  logic                 in_stall;
  logic                 out_valid;
  out_item_t            out_item;
  logic                 out_stall = 1'b0;

  hotplug_tracker governor;

  // Idling knobs, percent of cycles; the receiver hold-off is requested by
  // the stimulus and counted down by the receiver itself.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off_req  = 1'b0;
  int hold_left     = 0;
  int items_sent    = 0;

  always #4 clk = ~clk;

  core_hotplug_load_governor_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall)
  );

  // --------------------------------------------------------------------------
  // Receiver: check each decision taken at this edge, then pick the stall
  // for the next cycle. A pending hold-off overrides the random stall so the
  // queue inside the block fills and the input side backs up.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) governor.take_decision(out_item);
    if (hold_off_req) begin
      hold_off_req = 1'b0;
      hold_left    = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Hard stop in case the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("status: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic in_item_t make_request(logic [1:0] cmd, int core,
                                            logic [FREQ_W-1:0] khz, bit last);
    in_item_t req;
    req.cmd         = cmd;
    req.core_index  = CORE_W'(core);
    req.freq_khz    = khz;
    req.last_sample = last;
    return req;
  endfunction

  function automatic logic [FREQ_W-1:0] clamp_khz(longint unsigned v);
    return (v > FREQ_MAX) ? FREQ_W'(FREQ_MAX) : FREQ_W'(v);
  endfunction

  // Pick a frequency relative to the current up and down thresholds, so that
  // ticks land on either side of them and right on the boundaries.
  function automatic logic [FREQ_W-1:0] pick_khz(load_t load);
    longint unsigned up_khz, down_khz;
    up_khz   = governor.threshold(governor.up_pct);
    down_khz = governor.threshold(governor.down_pct);
    case (load)
      LOAD_HIGH: begin
        if (up_khz >= FREQ_MAX) return FREQ_W'(FREQ_MAX);
        return FREQ_W'($urandom_range(FREQ_MAX, 32'(up_khz) + 1));
      end
      LOAD_LOW: begin
        if (down_khz == 0) return '0;
        return FREQ_W'($urandom_range(32'(clamp_khz(down_khz - 1)), 0));
      end
      LOAD_EDGE: begin
        case ($urandom_range(5))
          0:       return '0;
          1:       return FREQ_W'(FREQ_MAX);
          2:       return clamp_khz(up_khz);
          3:       return clamp_khz(up_khz + 1);
          4:       return clamp_khz((down_khz == 0) ? 0 : down_khz - 1);
          default: return clamp_khz(down_khz);
        endcase
      end
      default: return FREQ_W'($urandom);
    endcase
  endfunction

  // Mostly in range; now and then any value the register width holds
  function automatic int pick_reg(int lo, int hi, int width);
    if ($urandom_range(9) == 0) return $urandom_range((1 << width) - 1);
    return $urandom_range(hi, lo);
  endfunction

  // Hold the request until the block takes it, then fold it into the model.
  // Valid stays high into the next request unless the sender idles.
  task automatic send_request(input in_item_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    governor.take_request(req);
    items_sent++;
  endtask

  // Drop valid and wait until every decision is back and the queue has
  // emptied of requests that produce none.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (governor.due_decisions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all registers back to back, one per cycle, while the block is idle
  task automatic program_regs(int up, int down, int most, int least,
                              int t_up, int t_down, int khz, bit on);
    logic [CFG_DW-1:0] vals [NUM_REGS];
    vals[REG_UP_PCT]     = CFG_DW'(up);
    vals[REG_DOWN_PCT]   = CFG_DW'(down);
    vals[REG_MAX_ONLINE] = CFG_DW'(most);
    vals[REG_MIN_ONLINE] = CFG_DW'(least);
    vals[REG_TICKS_UP]   = CFG_DW'(t_up);
    vals[REG_TICKS_DOWN] = CFG_DW'(t_down);
    vals[REG_MAX_FREQ]   = CFG_DW'(khz);
    vals[REG_GOV_ON]     = CFG_DW'(on);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      governor.write_reg(CFG_IDX_W'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // One tick in ascending core order. Offline cores sometimes report too,
  // and a single-sample tick exercises short ticks and counter buildup.
  task automatic send_tick(bit single);
    int    cores[$];
    load_t load;
    bit    mixed;
    load  = load_t'($urandom_range(3));
    mixed = ($urandom_range(3) == 0);
    if (single) begin
      cores.push_back($urandom_range(1) ? 0 : $urandom_range(NUM_CORES - 1));
    end else begin
      for (int c = 0; c < NUM_CORES; c++)
        if (governor.online[c] || $urandom_range(4) == 0) cores.push_back(c);
    end
    if (cores.size() == 0) cores.push_back(0);
    foreach (cores[i])
      send_request(make_request(CMD_SAMPLE, cores[i],
                                pick_khz(mixed ? load_t'($urandom_range(3)) : load),
                                i == cores.size() - 1));
  endtask

  // Mostly well-formed ticks; some screen toggles, stray samples and the
  // unused command mixed in. Wake up soon after a screen-off.
  task automatic send_random_unit();
    int pick;
    pick = $urandom_range(99);
    if (pick < 3)
      send_request(make_request(CMD_OFF, $urandom_range(NUM_CORES - 1),
                                FREQ_W'($urandom), 1'($urandom_range(1))));
    else if (pick < 5 || (governor.asleep && pick < 35))
      send_request(make_request(CMD_ON, $urandom_range(NUM_CORES - 1),
                                FREQ_W'($urandom), 1'($urandom_range(1))));
    else if (pick < 6)
      send_request(make_request(CMD_UNUSED, $urandom_range(NUM_CORES - 1),
                                FREQ_W'($urandom), 1'($urandom_range(1))));
    else if (pick < 10)
      send_request(make_request(CMD_SAMPLE, $urandom_range(NUM_CORES - 1),
                                FREQ_W'($urandom), 1'($urandom_range(1))));
    else
      send_tick(pick < 40);
  endtask

  task automatic run_phase(phase_t kind, int budget, bit pressure);
    int start_items;
    wait_drained();
    case (kind)
      PH_RANDOM:
        program_regs(pick_reg(0, 100, 7), pick_reg(0, 100, 7), pick_reg(1, 8, 4),
                     pick_reg(1, 8, 4), pick_reg(0, 8, 8), pick_reg(0, 8, 8),
                     pick_reg(0, FREQ_MAX, FREQ_W), 1'b1);
      // everything adds and everything removes, no wait between changes
      PH_EXT_A:    program_regs(0, 100, 8, 1, 0, 0, FREQ_MAX, 1'b1);
      // out-of-range percents and limits, zero frequency, longest waits
      PH_EXT_B:    program_regs(127, 127, 1, 15, 255, 255, 0, 1'b1);
      PH_GOV_OFF:
        program_regs(pick_reg(0, 100, 7), pick_reg(0, 100, 7), pick_reg(1, 8, 4),
                     pick_reg(1, 8, 4), pick_reg(0, 8, 8), pick_reg(0, 8, 8),
                     pick_reg(0, FREQ_MAX, FREQ_W), 1'b0);
      PH_SATURATE: program_regs(90, 60, 15, 1, 255, 255, 2000000, 1'b1);
      default: ;
    endcase
    if (pressure) hold_off_req = 1'b1;
    // wake the governor so the core-0-only ticks count up
    if (kind == PH_SATURATE) send_request(make_request(CMD_ON, 0, '0, 1'b0));
    start_items = items_sent;
    while (items_sent - start_items < budget) begin
      if (kind == PH_SATURATE && items_sent - start_items < SATURATE_TICKS)
        send_request(make_request(CMD_SAMPLE, 0, pick_khz(LOAD_LOW), 1'b1));
      else
        send_random_unit();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    governor      = new();
    send_idle_pct = 10;
    recv_idle_pct = 67;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corner cases under reset register values.
    // All cores fast but every core already online: no change.
    send_request(make_request(CMD_SAMPLE, 0, FREQ_W'(FREQ_MAX), 1'b0));
    send_request(make_request(CMD_SAMPLE, 1, 22'd2000000, 1'b1));
    // Two cores tie for slowest; the later one (core 5) goes down.
    send_request(make_request(CMD_SAMPLE, 0, 22'd100, 1'b0));
    send_request(make_request(CMD_SAMPLE, 3, '0, 1'b0));
    send_request(make_request(CMD_SAMPLE, 5, '0, 1'b1));
    // Offline core reports: ignored, but its last mark closes the tick.
    send_request(make_request(CMD_SAMPLE, 5, '0, 1'b1));
    // A sample that becomes the new slowest is not seen by the fastest.
    send_request(make_request(CMD_SAMPLE, 1, 22'd500, 1'b0));
    send_request(make_request(CMD_SAMPLE, 2, FREQ_W'(FREQ_MAX), 1'b0));
    send_request(make_request(CMD_SAMPLE, 3, 22'd400, 1'b1));
    // Core 0 alone above the up threshold brings back the lowest offline core.
    send_request(make_request(CMD_SAMPLE, 0, 22'd2500000, 1'b1));
    // Unused command, screen off, a tick while asleep, screen on.
    send_request(make_request(CMD_UNUSED, 7, FREQ_W'(FREQ_MAX), 1'b1));
    send_request(make_request(CMD_OFF, 3, '0, 1'b0));
    send_request(make_request(CMD_SAMPLE, 0, '0, 1'b1));
    send_request(make_request(CMD_ON, 7, FREQ_W'(FREQ_MAX), 1'b1));
    // Field extremes on the top core.
    send_request(make_request(CMD_SAMPLE, 7, '0, 1'b0));
    send_request(make_request(CMD_SAMPLE, 7, FREQ_W'(FREQ_MAX), 1'b1));

    // Sender idles lightly, receiver stalls heavily
    run_phase(PH_DEFAULT, 200, 1'b0);
    run_phase(PH_RANDOM, 200, 1'b0);
    run_phase(PH_EXT_A, 200, 1'b0);
    // Then the other way round
    send_idle_pct = 67;
    recv_idle_pct = 10;
    run_phase(PH_EXT_B, 200, 1'b1);
    run_phase(PH_GOV_OFF, 120, 1'b0);
    run_phase(PH_RANDOM, 200, 1'b0);
    // Then no idling at all
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(PH_SATURATE, 400, 1'b0);
    run_phase(PH_RANDOM, 200, 1'b1);
    run_phase(PH_RANDOM, 200, 1'b0);

    wait_drained();
    if (governor.errors == 0 && governor.due_decisions.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
